[rtl/core/hap_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hap_pkg
// Shared widths, NAL header constants and counter indexes for the Annex B
// start code probe.
// ---------------------------------------------------------------------------
package hap_pkg;

  // Width of the internal saturating unit counters.
  localparam int COUNT_BITS = 16;

  localparam int BYTE_W   = 8;
  localparam int SCORE_W  = 7;
  localparam int CNT_W    = 16;
  localparam int TYPE_W   = 6;
  localparam int HIST_W   = 24;
  localparam int NUM_CNT  = 4;

  localparam logic [SCORE_W-1:0] SCORE_RESET = 7'd51;

  // Three-byte start code prefix 00 00 01 as seen in the byte history.
  localparam logic [HIST_W-1:0] START_CODE   = 24'h000001;
  localparam logic [HIST_W-1:0] HIST_RESET   = 24'hFFFFFF;

  // First header byte: forbidden_zero_bit and the top layer-id bit.
  localparam logic [BYTE_W-1:0] HDR1_BAD_MASK = 8'h81;
  // Second header byte: reserved bits above the temporal id.
  localparam logic [BYTE_W-1:0] HDR2_BAD_MASK = 8'hF8;

  // NAL unit types of interest.
  localparam logic [TYPE_W-1:0] NAL_VPS     = 6'd32;
  localparam logic [TYPE_W-1:0] NAL_SPS     = 6'd33;
  localparam logic [TYPE_W-1:0] NAL_PPS     = 6'd34;
  localparam logic [TYPE_W-1:0] NAL_IRAP_LO = 6'd16;
  localparam logic [TYPE_W-1:0] NAL_IRAP_HI = 6'd21;

  // Counter slots.
  localparam int CNT_VPS  = 0;
  localparam int CNT_SPS  = 1;
  localparam int CNT_PPS  = 2;
  localparam int CNT_IRAP = 3;

endpackage

[rtl/core/hap_channels.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hap_in_if / hap_out_if
// Valid/ready channels for probe input bytes and probe result items.
// ---------------------------------------------------------------------------
interface hap_in_if import hap_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface hap_out_if import hap_pkg::*;;
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] score;
  logic               rejected;
  logic [CNT_W-1:0]   vps_count;
  logic [CNT_W-1:0]   sps_count;
  logic [CNT_W-1:0]   pps_count;
  logic [CNT_W-1:0]   irap_count;

  modport source (output valid, output score, output rejected, output vps_count,
                  output sps_count, output pps_count, output irap_count,
                  input ready);
  modport sink   (input valid, input score, input rejected, input vps_count,
                  input sps_count, input pps_count, input irap_count,
                  output ready);
endinterface

[rtl/core/hevc_annexb_probe.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hevc_annexb_probe
// Byte-wise HEVC Annex B stream probe with unit counts and a match score.
// ---------------------------------------------------------------------------
// The probe takes one byte of a buffer per accepted item, with the last byte
// of the buffer flagged. It watches for the 00 00 01 start code, checks the
// two NAL header bytes that follow for forbidden or reserved bits, and keeps
// saturating counts of VPS, SPS, PPS and IRAP units. The last byte of a
// buffer only completes a pending second-byte check; in the cycle after it is
// accepted a single result item carries the four counts, the reject flag and
// a score (the configured match_score when all four counts are nonzero and
// nothing was rejected, otherwise 0). The scan state then returns to reset
// for the next buffer. Throughput is one byte per clock: the per-byte work is
// a shift, a compare and a counter update between the scan state registers
// and a single result register. Input is stalled only while a finished
// result sits in the result register and the sink does not take it.
// match_score should be written only while no buffer is in progress.
// ---------------------------------------------------------------------------
module hevc_annexb_probe import hap_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  hap_in_if.sink             in_ch,
  hap_out_if.source          out_ch,
  input  logic               cfg_wr_en,
  input  logic [SCORE_W-1:0] cfg_wr_data
);

  // Configuration.
  logic [SCORE_W-1:0] match_score;

  // Scan state.
  logic [HIST_W-1:0]                     byte_history;
  logic                                  header_pending;
  logic [TYPE_W-1:0]                     pending_type;
  logic                                  reject_flag;
  logic [NUM_CNT-1:0][COUNT_BITS-1:0]    unit_counters;

  // Result register.
  logic               res_valid;
  logic [SCORE_W-1:0] res_score;
  logic               res_rejected;
  logic [CNT_W-1:0]   res_vps;
  logic [CNT_W-1:0]   res_sps;
  logic [CNT_W-1:0]   res_pps;
  logic [CNT_W-1:0]   res_irap;

  logic accept;
  logic [BYTE_W-1:0] b;

  // Next-state values for the accepted byte.
  logic                               reject_mid;
  logic [NUM_CNT-1:0]                 bump;
  logic [NUM_CNT-1:0][COUNT_BITS-1:0] counters_mid;
  logic                               all_seen;
  logic                               hdr_hit;
  logic                               reject_next;
  logic                               header_pending_next;
  logic [TYPE_W-1:0]                  pending_type_next;
  logic [HIST_W-1:0]                  byte_history_next;

  // Accept whenever the result register is empty or being drained.
  assign in_ch.ready = !res_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;

  always_comb begin
    // Second-byte check of a pending unit; count it only if it passes.
    reject_mid = reject_flag;
    bump       = '0;
    if (header_pending && !reject_flag) begin
      if ((b & HDR2_BAD_MASK) != '0) begin
        reject_mid = 1'b1;
      end else begin
        bump[CNT_VPS]  = (pending_type == NAL_VPS);
        bump[CNT_SPS]  = (pending_type == NAL_SPS);
        bump[CNT_PPS]  = (pending_type == NAL_PPS);
        bump[CNT_IRAP] = pending_type inside {[NAL_IRAP_LO:NAL_IRAP_HI]};
      end
    end

    // Saturating increment: hold at all ones.
    for (int k = 0; k < NUM_CNT; k++) begin
      if (bump[k] && (unit_counters[k] != '1)) begin
        counters_mid[k] = COUNT_BITS'(unit_counters[k] + 1'b1);
      end else begin
        counters_mid[k] = unit_counters[k];
      end
    end

    all_seen = (counters_mid[CNT_VPS] != '0) && (counters_mid[CNT_SPS] != '0) &&
               (counters_mid[CNT_PPS] != '0) && (counters_mid[CNT_IRAP] != '0);

    // Header detection; never on the last byte of a buffer.
    hdr_hit             = !in_ch.last && (byte_history == START_CODE) && !reject_mid;
    reject_next         = reject_mid;
    header_pending_next = 1'b0;
    pending_type_next   = pending_type;
    if (hdr_hit) begin
      if ((b & HDR1_BAD_MASK) != '0) begin
        reject_next = 1'b1;
      end else begin
        header_pending_next = 1'b1;
        pending_type_next   = b[TYPE_W:1];
      end
    end
    byte_history_next = {byte_history[HIST_W-BYTE_W-1:0], b};
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_score <= SCORE_RESET;
    end else if (cfg_wr_en) begin
      match_score <= cfg_wr_data;
    end
  end

  // Scan state: advance on every accepted byte, clear after the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_history   <= HIST_RESET;
      header_pending <= 1'b0;
      pending_type   <= '0;
      reject_flag    <= 1'b0;
      unit_counters  <= '0;
    end else if (accept) begin
      if (in_ch.last) begin
        byte_history   <= HIST_RESET;
        header_pending <= 1'b0;
        pending_type   <= '0;
        reject_flag    <= 1'b0;
        unit_counters  <= '0;
      end else begin
        byte_history   <= byte_history_next;
        header_pending <= header_pending_next;
        pending_type   <= pending_type_next;
        reject_flag    <= reject_next;
        unit_counters  <= counters_mid;
      end
    end
  end

  // Result valid: set by an accepted last byte, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && in_ch.last) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload: load on the last byte, hold otherwise.
  always_ff @(posedge clk) begin
    if (accept && in_ch.last) begin
      res_score    <= (all_seen && !reject_mid) ? match_score : '0;
      res_rejected <= reject_mid;
      res_vps      <= CNT_W'(counters_mid[CNT_VPS]);
      res_sps      <= CNT_W'(counters_mid[CNT_SPS]);
      res_pps      <= CNT_W'(counters_mid[CNT_PPS]);
      res_irap     <= CNT_W'(counters_mid[CNT_IRAP]);
    end
  end

  assign out_ch.valid      = res_valid;
  assign out_ch.score      = res_score;
  assign out_ch.rejected   = res_rejected;
  assign out_ch.vps_count  = res_vps;
  assign out_ch.sps_count  = res_sps;
  assign out_ch.pps_count  = res_pps;
  assign out_ch.irap_count = res_irap;

`ifndef SYNTHESIS
  // A last byte always produces a result in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.last |=> res_valid)
    else $error("no result after last byte");

  // The scan state is back at reset after a last byte.
  a_last_clears_scan: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.last |=> (unit_counters == '0) && !reject_flag &&
                             !header_pending && (byte_history == HIST_RESET))
    else $error("scan state not cleared after last byte");

  // Once rejected, counts freeze until the buffer ends.
  a_reject_freezes: assert property (@(posedge clk) disable iff (rst)
    reject_flag && !(accept && in_ch.last) |=> reject_flag && $stable(unit_counters))
    else $error("counters moved after rejection");

  // A nonzero score is never reported with the rejected flag.
  a_score_not_rejected: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_score != '0) |-> !res_rejected)
    else $error("score reported for a rejected buffer");
`endif

endmodule

[sim/hevc_annexb_probe_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hevc_annexb_probe_test
// Self-checking bench for the Annex B start code probe.
// ---------------------------------------------------------------------------
// Byte items go in through the input channel and result items come back on
// the output channel. A predictor kept next to the stimulus tracks the
// start-code history, the pending second-byte check, the reject flag and the
// saturating unit counts. On every accepted last byte it queues the result
// item the probe must produce. A separate process takes result items with
// random stalls and compares them field by field, in order. Directed buffers
// cover the edge cases. Long runs of mostly well-formed parameter-set and IRAP
// units follow, with noise and damaged headers mixed in, under several
// match_score settings.
// ---------------------------------------------------------------------------
module hevc_annexb_probe_test;
  import hap_pkg::*;

  typedef logic [BYTE_W-1:0] bytes_t [$];

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               rejected;
    logic [CNT_W-1:0]   vps;
    logic [CNT_W-1:0]   sps;
    logic [CNT_W-1:0]   pps;
    logic [CNT_W-1:0]   irap;
  } probe_result_t;

  // Ways to damage one NAL unit on purpose.
  typedef enum int {FLAW_NONE, FLAW_HEADER, FLAW_SECOND} unit_flaw_e;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en;
  logic [SCORE_W-1:0] cfg_wr_data;

  hap_in_if  in_ch ();
  hap_out_if out_ch ();

  hevc_annexb_probe dut (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // Predictor state: a private copy of the scan registers and match_score.
  // ------------------------------------------------------------------------
  logic [HIST_W-1:0]     seen_bytes;
  logic                  second_due;
  logic [TYPE_W-1:0]     due_type;
  logic                  buffer_bad;
  logic [COUNT_BITS-1:0] unit_tally [NUM_CNT];
  logic [SCORE_W-1:0]    score_setting;

  probe_result_t expected_results [$];

  int unsigned mismatches   = 0;
  int unsigned bytes_fed    = 0;
  int unsigned results_due  = 0;

  // Idle switches for each side, and the long receiver hold-off.
  bit          src_idle    = 1'b0;
  bit          sink_idle   = 1'b0;
  bit          hold_go     = 1'b0;
  bit          sink_held   = 1'b0;
  int unsigned hold_cycles = 300;

  function automatic void clear_scan();
    seen_bytes = HIST_RESET;
    second_due = 1'b0;
    due_type   = '0;
    buffer_bad = 1'b0;
    foreach (unit_tally[k]) unit_tally[k] = '0;
  endfunction

  function automatic void bump_tally(int slot);
    if (unit_tally[slot] != {COUNT_BITS{1'b1}}) unit_tally[slot] = unit_tally[slot] + 1'b1;
  endfunction

  function automatic void tally_type(logic [TYPE_W-1:0] t);
    if (t == NAL_VPS) bump_tally(CNT_VPS);
    else if (t == NAL_SPS) bump_tally(CNT_SPS);
    else if (t == NAL_PPS) bump_tally(CNT_PPS);
    else if (t >= NAL_IRAP_LO && t <= NAL_IRAP_HI) bump_tally(CNT_IRAP);
  endfunction

  // Advance the predictor by one accepted byte; queue a result on the last one.
  function automatic void absorb_byte(logic [BYTE_W-1:0] b, logic is_last);
    probe_result_t r;
    logic          all_kinds;
    // Finish the second-byte check of a unit found on the previous byte.
    if (second_due) begin
      second_due = 1'b0;
      if (!buffer_bad) begin
        if ((b & HDR2_BAD_MASK) != '0) buffer_bad = 1'b1;
        else tally_type(due_type);
      end
    end
    if (!is_last) begin
      if (seen_bytes == START_CODE && !buffer_bad) begin
        if ((b & HDR1_BAD_MASK) != '0) begin
          buffer_bad = 1'b1;
        end else begin
          second_due = 1'b1;
          due_type   = b[6:1];
        end
      end
      seen_bytes = {seen_bytes[HIST_W-BYTE_W-1:0], b};
    end else begin
      // The last byte never opens a unit; report and start over.
      all_kinds = (unit_tally[CNT_VPS] != '0) && (unit_tally[CNT_SPS] != '0) &&
                  (unit_tally[CNT_PPS] != '0) && (unit_tally[CNT_IRAP] != '0);
      r.score    = (all_kinds && !buffer_bad) ? score_setting : '0;
      r.rejected = buffer_bad;
      r.vps      = CNT_W'(unit_tally[CNT_VPS]);
      r.sps      = CNT_W'(unit_tally[CNT_SPS]);
      r.pps      = CNT_W'(unit_tally[CNT_PPS]);
      r.irap     = CNT_W'(unit_tally[CNT_IRAP]);
      expected_results.push_back(r);
      results_due++;
      clear_scan();
    end
  endfunction

  // ------------------------------------------------------------------------
  // Buffer building
  // ------------------------------------------------------------------------
  function automatic logic [BYTE_W-1:0] noise_byte();
    // Lean toward 00 and 01 so that stray start codes show up in the noise.
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 1) ? 8'h00 : 8'h01;
    return 8'($urandom);
  endfunction

  function automatic logic [TYPE_W-1:0] pick_type();
    case ($urandom_range(0, 7))
      0:       return NAL_VPS;
      1:       return NAL_SPS;
      2:       return NAL_PPS;
      3:       return TYPE_W'($urandom_range(NAL_IRAP_LO, NAL_IRAP_HI));
      default: return TYPE_W'($urandom_range(0, 63));
    endcase
  endfunction

  // Append 00 00 01, the header byte and the second header byte.
  function automatic void add_unit(ref bytes_t s, input logic [TYPE_W-1:0] t,
                                   input unit_flaw_e flaw);
    logic [BYTE_W-1:0] hdr;
    logic [BYTE_W-1:0] tail;
    logic [1:0]        bad;
    hdr  = {1'b0, t, 1'b0};
    tail = {5'b0, 3'($urandom)};
    if (flaw == FLAW_HEADER) begin
      bad = 2'($urandom_range(1, 3));
      hdr = hdr | {bad[1], 6'b0, bad[0]};
    end else if (flaw == FLAW_SECOND) begin
      tail = tail | {5'($urandom_range(1, 31)), 3'b0};
    end
    s.push_back(8'h00);
    s.push_back(8'h00);
    s.push_back(8'h01);
    s.push_back(hdr);
    s.push_back(tail);
  endfunction

  function automatic void add_full_set(ref bytes_t s);
    add_unit(s, NAL_VPS, FLAW_NONE);
    add_unit(s, NAL_SPS, FLAW_NONE);
    add_unit(s, NAL_PPS, FLAW_NONE);
    add_unit(s, TYPE_W'($urandom_range(NAL_IRAP_LO, NAL_IRAP_HI)), FLAW_NONE);
  endfunction

  function automatic void build_random_buffer(ref bytes_t s);
    int unsigned       style;
    int                flawed;
    logic [TYPE_W-1:0] kinds [$];
    s.delete();
    style = $urandom_range(0, 99);
    if (style < 5) begin
      // Single-byte buffer: nothing to scan.
      s.push_back(8'($urandom));
      return;
    end
    if (style < 20) begin
      repeat ($urandom_range(1, 12)) s.push_back(noise_byte());
    end else begin
      // Well-formed units; half of them carry every kind the score needs.
      if (style < 60) begin
        kinds.push_back(NAL_VPS);
        kinds.push_back(NAL_SPS);
        kinds.push_back(NAL_PPS);
        kinds.push_back(TYPE_W'($urandom_range(NAL_IRAP_LO, NAL_IRAP_HI)));
      end
      repeat ($urandom_range(0, 3)) kinds.insert($urandom_range(0, kinds.size()), pick_type());
      if (kinds.size() == 0) kinds.push_back(pick_type());
      flawed = (style >= 85) ? int'($urandom_range(0, kinds.size() - 1)) : -1;
      foreach (kinds[k]) begin
        if ($urandom_range(0, 3) == 0) s.push_back(8'h00);
        if (k == flawed) add_unit(s, kinds[k], $urandom_range(0, 1) ? FLAW_HEADER : FLAW_SECOND);
        else add_unit(s, kinds[k], FLAW_NONE);
        repeat ($urandom_range(0, 3)) s.push_back(noise_byte());
      end
    end
    // Pick how the buffer ends.
    case ($urandom_range(0, 3))
      0: begin
        // Start code that completes on the last byte: ignored.
        s.push_back(8'h00);
        s.push_back(8'h00);
        s.push_back(8'h01);
        s.push_back(8'($urandom));
      end
      1: begin
        // Last byte is the second byte of a pending unit.
        add_unit(s, pick_type(), $urandom_range(0, 2) == 0 ? FLAW_SECOND : FLAW_NONE);
      end
      default: s.push_back(8'($urandom));
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // Driving: inputs change at the falling edge, handshakes sampled at rising.
  // ------------------------------------------------------------------------
  task automatic feed_byte(input logic [BYTE_W-1:0] b, input logic is_last);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.data_byte = b;
    in_ch.last      = is_last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    absorb_byte(b, is_last);
    bytes_fed++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic feed_buffer(input bytes_t s);
    foreach (s[i]) feed_byte(s[i], i == s.size() - 1);
  endtask

  // Only called with the probe idle: the new value takes effect at the edge.
  task automatic write_match_score(input logic [SCORE_W-1:0] value);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(posedge clk);
    score_setting = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Hold until every queued result is back, then idle a little longer.
  task automatic wait_drained();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // ------------------------------------------------------------------------
  // Result side
  // ------------------------------------------------------------------------
  function automatic void check_field(string field, logic [CNT_W-1:0] want,
                                      logic [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // Long receiver hold-off, counted in clock cycles.
  initial begin : sink_hold_off
    forever begin
      @(posedge hold_go);
      @(posedge clk);
      sink_held = 1'b1;
      repeat (hold_cycles) @(posedge clk);
      sink_held = 1'b0;
    end
  end

  initial begin : result_sink
    int unsigned   stall;
    probe_result_t want;
    out_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      stall = sink_idle ? $urandom_range(0, 14) : 0;
      out_ch.ready = 1'b0;
      repeat (stall) @(negedge clk);
      while (sink_held) @(negedge clk);
      out_ch.ready = 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      if (expected_results.size() == 0) begin
        $error("result item arrived with nothing expected");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("score",      CNT_W'(want.score),    CNT_W'(out_ch.score));
        check_field("rejected",   CNT_W'(want.rejected), CNT_W'(out_ch.rejected));
        check_field("vps_count",  want.vps,      out_ch.vps_count);
        check_field("sps_count",  want.sps,      out_ch.sps_count);
        check_field("pps_count",  want.pps,      out_ch.pps_count);
        check_field("irap_count", want.irap,     out_ch.irap_count);
      end
    end
  end

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Reset value of match_score, and one-byte buffers at both byte extremes.
  task automatic test_reset_defaults();
    bytes_t s;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    feed_byte(8'h00, 1'b1);
    feed_byte(8'hFF, 1'b1);
    add_full_set(s);
    s.push_back(8'hFF);
    feed_buffer(s);
  endtask

  // Each counted kind, IRAP range edges, and types just outside the ranges.
  task automatic test_unit_kinds();
    bytes_t s;
    wait_drained();
    write_match_score(7'd100);
    add_unit(s, NAL_VPS, FLAW_NONE);
    add_unit(s, NAL_IRAP_LO - 1'b1, FLAW_NONE);
    add_unit(s, NAL_SPS, FLAW_NONE);
    add_unit(s, NAL_IRAP_HI + 1'b1, FLAW_NONE);
    add_unit(s, NAL_PPS, FLAW_NONE);
    add_unit(s, NAL_IRAP_HI, FLAW_NONE);
    add_unit(s, NAL_IRAP_LO, FLAW_NONE);
    add_unit(s, NAL_PPS + 1'b1, FLAW_NONE);
    s.push_back(8'h00);
    feed_buffer(s);
    // Missing PPS: counts but no score.
    s.delete();
    add_unit(s, NAL_VPS, FLAW_NONE);
    add_unit(s, NAL_SPS, FLAW_NONE);
    add_unit(s, NAL_IRAP_LO, FLAW_NONE);
    s.push_back(8'h80);
    feed_buffer(s);
  endtask

  // Bad header bits freeze the counts for the rest of the buffer.
  task automatic test_header_rejects();
    bytes_t s;
    add_full_set(s);
    add_unit(s, NAL_SPS, FLAW_HEADER);
    add_unit(s, NAL_VPS, FLAW_NONE);
    s.push_back(8'h7F);
    feed_buffer(s);
    // A unit is counted only once its second byte passes.
    s.delete();
    add_unit(s, NAL_VPS, FLAW_NONE);
    add_unit(s, NAL_SPS, FLAW_SECOND);
    add_unit(s, NAL_PPS, FLAW_NONE);
    s.push_back(8'h01);
    feed_buffer(s);
  endtask

  // Start code on the last byte, and the last byte as a pending second byte.
  task automatic test_buffer_edges();
    bytes_t s;
    s = '{8'h00, 8'h00, 8'h01, 8'h81};
    feed_buffer(s);
    s.delete();
    add_unit(s, NAL_VPS, FLAW_NONE);
    s.push_back(8'h00);
    s.push_back(8'h00);
    s.push_back(8'h01);
    s.push_back({1'b0, NAL_SPS, 1'b0});
    s.push_back(8'h07);
    feed_buffer(s);
    s = '{8'h00, 8'h00, 8'h01, {1'b0, NAL_PPS, 1'b0}, 8'hF8};
    feed_buffer(s);
  endtask

  // Score register at both ends of its width, including above 100.
  task automatic test_score_extremes();
    bytes_t s;
    wait_drained();
    write_match_score(7'd0);
    add_full_set(s);
    s.push_back(8'h55);
    feed_buffer(s);
    wait_drained();
    write_match_score(7'd127);
    feed_buffer(s);
  endtask

  // A long run of chained VPS units in one buffer, at full rate.
  task automatic test_count_run();
    bytes_t s;
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    s.push_back(8'h00);
    s.push_back(8'h00);
    s.push_back(8'h01);
    // Header, then a 00 second byte that also opens the next start code.
    repeat (20) begin
      s.push_back({1'b0, NAL_VPS, 1'b0});
      s.push_back(8'h00);
      s.push_back(8'h00);
      s.push_back(8'h01);
    end
    s.push_back({1'b0, NAL_SPS, 1'b0});
    s.push_back(8'h00);
    add_unit(s, NAL_PPS, FLAW_NONE);
    add_unit(s, NAL_IRAP_HI, FLAW_NONE);
    s.push_back(8'hC3);
    feed_buffer(s);
  endtask

  // Receiver holds off while the sender keeps offering back-to-back buffers,
  // so the result register fills and input stalls; then the sender waits.
  task automatic test_backpressure();
    bytes_t s;
    wait_drained();
    write_match_score(7'd42);
    src_idle    = 1'b0;
    sink_idle   = 1'b0;
    hold_cycles = 300;
    hold_go     = 1'b1;
    repeat (6) begin
      build_random_buffer(s);
      feed_buffer(s);
    end
    wait_drained();
    hold_go = 1'b0;
  endtask

  // Random buffers over several score settings and idle mixes.
  task automatic test_random_traffic();
    bytes_t             s;
    int unsigned        first_byte;
    int unsigned        first_result;
    logic [SCORE_W-1:0] phase_score;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       phase_score = 7'd0;
        1:       phase_score = 7'd127;
        2:       phase_score = 7'd100;
        3:       phase_score = SCORE_W'($urandom_range(1, 126));
        default: phase_score = SCORE_RESET;
      endcase
      wait_drained();
      write_match_score(phase_score);
      // Both idle, sender only, receiver only, neither, both again.
      src_idle     = (p != 2) && (p != 3);
      sink_idle    = (p != 1) && (p != 3);
      first_byte   = bytes_fed;
      first_result = results_due;
      while (bytes_fed - first_byte < 90 || results_due - first_result < 5) begin
        build_random_buffer(s);
        feed_buffer(s);
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------
  initial begin : stimulus
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last      = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    score_setting   = SCORE_RESET;
    clear_scan();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_unit_kinds();
    test_header_rejects();
    test_buffer_edges();
    test_score_extremes();
    test_count_run();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop: 10 ms, far beyond the slowest legal run.
  initial begin : watchdog
    #(10_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

[sim.f]
rtl/core/hap_pkg.sv
rtl/core/hap_channels.sv
rtl/core/hevc_annexb_probe.sv
sim/hevc_annexb_probe_test.sv
